@@ src/pgref_pkg.sv @@
// ----------------------------------------------------------------------------
// Page allocator package
// Shared field widths, request and status codes, and the result record of
// the count update unit.
// ----------------------------------------------------------------------------
package pgref_pkg;

   localparam int TYPE_W   = 3;
   localparam int PAGE_W   = 16;
   localparam int STATUS_W = 3;
   localparam int GRANT_W  = 15;
   localparam int COUNT_W  = 16;
   localparam int FIRST_W  = 15;

   typedef logic [TYPE_W-1:0]   req_code_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [COUNT_W-1:0]  count_type;

   // Request codes.
   localparam req_code_type REQ_ALLOC = 3'd0;
   localparam req_code_type REQ_FREE  = 3'd1;
   localparam req_code_type REQ_ADD   = 3'd2;
   localparam req_code_type REQ_READ  = 3'd3;
   localparam req_code_type REQ_INIT  = 3'd4;

   // Status codes.
   localparam status_type ST_OK       = 3'd0;
   localparam status_type ST_RANGE    = 3'd1;
   localparam status_type ST_BADCOUNT = 3'd2;
   localparam status_type ST_NOMEM    = 3'd3;
   localparam status_type ST_OVERFLOW = 3'd4;

   localparam count_type COUNT_MAX = 16'hFFFF;

   // Outcome of one count update.
   typedef struct packed {
      status_type status;
      count_type  count;
      logic       wr_en;
      logic       push;
      logic       pop;
   } cnt_res_type;

endpackage

@@ src/pgref_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pgref_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ src/pgref_count_unit.sv @@
// ----------------------------------------------------------------------------
// Count update unit
// The single increment/decrement adder and its checks, shared by the alloc,
// free, add_ref and read_count requests; init clears counts without it.
// ----------------------------------------------------------------------------
module pgref_count_unit (
   input  pgref_pkg::req_code_type op,
   input  pgref_pkg::count_type    count_in,
   output pgref_pkg::cnt_res_type  res
);

   pgref_pkg::count_type addend;
   pgref_pkg::count_type sum;
   logic                 is_zero;
   logic                 is_max;

   // One adder: minus one for a free, plus one otherwise.
   assign addend  = (op == pgref_pkg::REQ_FREE) ? '1 : pgref_pkg::COUNT_W'(1);
   assign sum     = count_in + addend;
   assign is_zero = (count_in == '0);
   assign is_max  = (count_in == pgref_pkg::COUNT_MAX);

   // Status and write decision per request type.
   always_comb begin
      res.status = pgref_pkg::ST_OK;
      res.count  = '0;
      res.wr_en  = 1'b0;
      res.push   = 1'b0;
      res.pop    = 1'b0;
      unique case (op)
         pgref_pkg::REQ_ALLOC: begin
            if (!is_zero) begin
               res.status = pgref_pkg::ST_BADCOUNT;
               res.count  = count_in;
            end else begin
               res.count = sum;
               res.wr_en = 1'b1;
               res.pop   = 1'b1;
            end
         end
         pgref_pkg::REQ_FREE: begin
            if (is_zero) begin
               res.status = pgref_pkg::ST_BADCOUNT;
            end else begin
               res.count = sum;
               res.wr_en = 1'b1;
               res.push  = (sum == '0);
            end
         end
         pgref_pkg::REQ_ADD: begin
            if (is_zero) begin
               res.status = pgref_pkg::ST_BADCOUNT;
            end else if (is_max) begin
               res.status = pgref_pkg::ST_OVERFLOW;
               res.count  = pgref_pkg::COUNT_MAX;
            end else begin
               res.count = sum;
               res.wr_en = 1'b1;
            end
         end
         pgref_pkg::REQ_READ: begin
            if (is_zero) begin
               res.status = pgref_pkg::ST_BADCOUNT;
            end else begin
               res.count = count_in;
            end
         end
         default: begin
            res.status = pgref_pkg::ST_OK;
         end
      endcase
   end

endmodule

@@ src/page_allocator_refcount_core.sv @@
// ----------------------------------------------------------------------------
// Page allocator with reference counts
// Keeps a last-in-first-out stack of free pages and a count for every page.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the req_ channel (valid/ready) with a type and a page
// number; each produces one transaction on the rsp_ channel with a status,
// the granted page and the resulting count. csr_wr_en writes the first page
// owned by the allocator; write it only while the block is idle.
// A request is worked on alone: req_ready is low from acceptance until the
// response has been placed in the output register. An alloc passes through
// the start, stack-read, count and output states; free, add_ref and
// read_count through start, count and output; requests rejected at once
// (range, empty stack, unknown type) from start to output; and init, which
// walks every page once, through start, sweep and output. The next request
// is taken in idle, after the response is loaded. An alloc reads the stack
// RAM, then the count RAM, both registered, then does one count update.
// After reset the count RAM is cleared, one page per cycle, with req_ready
// low. A stalled receiver holds the response in the output register; the
// block still takes and works one more request, then keeps its result back,
// with req_ready low, until the register frees.
// ----------------------------------------------------------------------------
module page_allocator_refcount_core #(
   parameter int NUM_PAGES = 32768
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_wr_en,
   input  logic [pgref_pkg::FIRST_W-1:0]      csr_wr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [pgref_pkg::TYPE_W-1:0]       req_type,
   input  logic [pgref_pkg::PAGE_W-1:0]       req_page_number,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pgref_pkg::STATUS_W-1:0]     rsp_status,
   output logic [pgref_pkg::GRANT_W-1:0]      rsp_granted_page,
   output logic [pgref_pkg::COUNT_W-1:0]      rsp_ref_count
);

   localparam int IDXW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
   localparam int DW   = $clog2(NUM_PAGES + 1);
   localparam int SW   = ((IDXW > pgref_pkg::FIRST_W) ? IDXW : pgref_pkg::FIRST_W) + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_STK   = 3'd2;
   localparam logic [2:0] S_CNT   = 3'd3;
   localparam logic [2:0] S_SWEEP = 3'd4;
   localparam logic [2:0] S_CLEAR = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]                       state_ff, state_in;
   logic [pgref_pkg::FIRST_W-1:0]    first_ff;
   pgref_pkg::req_code_type          type_ff, type_in;
   logic [pgref_pkg::PAGE_W-1:0]     page_ff, page_in;
   logic [IDXW-1:0]                  addr_ff, addr_in;
   logic [IDXW-1:0]                  idx_ff, idx_in;
   logic [DW-1:0]                    depth_ff, depth_in;
   pgref_pkg::status_type            hold_status_ff, hold_status_in;
   logic [pgref_pkg::GRANT_W-1:0]    hold_grant_ff, hold_grant_in;
   pgref_pkg::count_type             hold_count_ff, hold_count_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   pgref_pkg::status_type            rsp_status_ff;
   logic [pgref_pkg::GRANT_W-1:0]    rsp_grant_ff;
   pgref_pkg::count_type             rsp_count_ff;

   logic                             cnt_we;
   logic [IDXW-1:0]                  cnt_waddr;
   pgref_pkg::count_type             cnt_wdata;
   logic [IDXW-1:0]                  cnt_raddr;
   pgref_pkg::count_type             cnt_rdata;
   logic                             stk_we;
   logic [IDXW-1:0]                  stk_waddr;
   logic [IDXW-1:0]                  stk_wdata;
   logic [IDXW-1:0]                  stk_raddr;
   logic [IDXW-1:0]                  stk_rdata;

   pgref_pkg::cnt_res_type           unit_res;
   logic                             page_valid;
   logic                             page_owned;
   logic                             sweep_last;
   logic [SW-1:0]                    fill_page;
   logic                             fill_ok;
   logic                             first_in_range;
   logic                             stack_full;
   logic                             out_free;

   // Memories for the counts and the free stack.
   pgref_ram #(.WIDTH(pgref_pkg::COUNT_W), .DEPTH(NUM_PAGES)) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   pgref_ram #(.WIDTH(IDXW), .DEPTH(NUM_PAGES)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_we),
      .wr_addr (stk_waddr),
      .wr_data (stk_wdata),
      .rd_addr (stk_raddr),
      .rd_data (stk_rdata)
   );

   // Shared count update unit.
   pgref_count_unit u_count_unit (
      .op       (type_ff),
      .count_in (cnt_rdata),
      .res      (unit_res)
   );

   // Page checks and sweep arithmetic.
   assign page_valid     = (32'(page_ff) < 32'(NUM_PAGES));
   assign page_owned     = page_valid && (page_ff >= pgref_pkg::PAGE_W'(first_ff));
   assign sweep_last     = (idx_ff == IDXW'(NUM_PAGES - 1));
   assign fill_page      = SW'(first_ff) + SW'(idx_ff);
   assign fill_ok        = (fill_page < SW'(NUM_PAGES));
   assign first_in_range = (SW'(first_ff) < SW'(NUM_PAGES));
   assign stack_full     = (depth_ff >= DW'(NUM_PAGES));
   assign out_free       = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == S_IDLE);

   // Read addresses: the count read follows the stack read on an alloc.
   assign stk_raddr = IDXW'(depth_ff - DW'(1));
   assign cnt_raddr = (state_ff == S_STK) ? stk_rdata : IDXW'(page_ff);

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      type_in        = type_ff;
      page_in        = page_ff;
      addr_in        = addr_ff;
      idx_in         = idx_ff;
      depth_in       = depth_ff;
      hold_status_in = hold_status_ff;
      hold_grant_in  = hold_grant_ff;
      hold_count_in  = hold_count_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      cnt_we         = 1'b0;
      cnt_waddr      = addr_ff;
      cnt_wdata      = unit_res.count;
      stk_we         = 1'b0;
      stk_waddr      = IDXW'(depth_ff);
      stk_wdata      = addr_ff;
      unique case (state_ff)
         S_CLEAR: begin
            cnt_we    = 1'b1;
            cnt_waddr = idx_ff;
            cnt_wdata = '0;
            idx_in    = idx_ff + IDXW'(1);
            if (sweep_last) begin
               idx_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               type_in  = req_type;
               page_in  = req_page_number;
               state_in = S_START;
            end
         end
         S_START: begin
            hold_status_in = pgref_pkg::ST_OK;
            hold_grant_in  = '0;
            hold_count_in  = '0;
            addr_in        = IDXW'(page_ff);
            idx_in         = '0;
            unique case (type_ff)
               pgref_pkg::REQ_ALLOC: begin
                  if (depth_ff == '0) begin
                     hold_status_in = pgref_pkg::ST_NOMEM;
                     state_in       = S_OUT;
                  end else begin
                     state_in = S_STK;
                  end
               end
               pgref_pkg::REQ_FREE: begin
                  if (!page_owned) begin
                     hold_status_in = pgref_pkg::ST_RANGE;
                     state_in       = S_OUT;
                  end else begin
                     state_in = S_CNT;
                  end
               end
               pgref_pkg::REQ_ADD,
               pgref_pkg::REQ_READ: begin
                  if (!page_valid) begin
                     hold_status_in = pgref_pkg::ST_RANGE;
                     state_in       = S_OUT;
                  end else begin
                     state_in = S_CNT;
                  end
               end
               pgref_pkg::REQ_INIT: begin
                  state_in = S_SWEEP;
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end
         S_STK: begin
            // The top of the stack is the page under test.
            addr_in  = stk_rdata;
            state_in = S_CNT;
         end
         S_CNT: begin
            cnt_we         = unit_res.wr_en;
            hold_status_in = unit_res.status;
            hold_count_in  = unit_res.count;
            if (unit_res.pop) begin
               hold_grant_in = pgref_pkg::GRANT_W'(addr_ff);
               depth_in      = depth_ff - DW'(1);
            end
            if (unit_res.push && !stack_full) begin
               stk_we   = 1'b1;
               depth_in = depth_ff + DW'(1);
            end
            state_in = S_OUT;
         end
         S_SWEEP: begin
            // Clear one count and, while the fill page is in range, lay down one stack entry per cycle.
            cnt_we    = 1'b1;
            cnt_waddr = idx_ff;
            cnt_wdata = '0;
            stk_we    = fill_ok;
            stk_waddr = idx_ff;
            stk_wdata = IDXW'(fill_page);
            idx_in    = idx_ff + IDXW'(1);
            if (sweep_last) begin
               idx_in   = '0;
               depth_in = first_in_range ?
                          DW'(SW'(NUM_PAGES) - SW'(first_ff)) : '0;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         idx_ff       <= '0;
         depth_ff     <= '0;
         first_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            first_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      type_ff        <= type_in;
      page_ff        <= page_in;
      addr_ff        <= addr_in;
      hold_status_ff <= hold_status_in;
      hold_grant_ff  <= hold_grant_in;
      hold_count_ff  <= hold_count_in;
      if ((state_ff == S_OUT) && out_free) begin
         rsp_status_ff <= hold_status_ff;
         rsp_grant_ff  <= hold_grant_ff;
         rsp_count_ff  <= hold_count_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_granted_page = rsp_grant_ff;
   assign rsp_ref_count    = rsp_count_ff;

   // The free stack never holds more pages than exist.
   assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DW'(NUM_PAGES))
   else $error("free stack depth beyond page count");

   // Only one request is in flight at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
   else $error("request accepted while another is in progress");

   // A response is issued only from the output state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT))
   else $error("response raised outside the output state");

   // An alloc that succeeds hands out a page with count one.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CNT && unit_res.pop) |-> (unit_res.count == pgref_pkg::COUNT_W'(1)))
   else $error("allocated page count is not one");

endmodule
